/* hw/rtl/srsm_pkg.sv */
// Shared constants and types for the sorted range set merge block.
package srsm_pkg;

    localparam int MAX_RANGES_DEF = 16;
    localparam int ADDR_W         = 32;
    localparam int END_W          = ADDR_W + 1;
    localparam int ENTRY_W        = 2 * ADDR_W;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Compare results of one stored entry against the working bounds.
    typedef struct packed {
        logic [END_W-1:0]  e_end;       // entry start + size, no wrap
        logic [ADDR_W-1:0] span;        // (hi - lo) mod 2^32
        logic              end_lt_lo;
        logic              start_gt_hi;
        logic              start_lt_hi;
        logic              end_gt_hi;
        logic              start_lt_lo;
        logic              lo_lt_end;
    } t_cmp_res;

endpackage

/* hw/rtl/srsm_ram.sv */
// Generic single write port, single read port RAM with registered read.
module srsm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/srsm_cmp_unit.sv */
// Shared compare unit: one stored entry against the working lo/hi bounds.
module srsm_cmp_unit (
    input  logic [srsm_pkg::ADDR_W-1:0] i_start,
    input  logic [srsm_pkg::ADDR_W-1:0] i_size,
    input  logic [srsm_pkg::END_W-1:0]  i_lo,
    input  logic [srsm_pkg::END_W-1:0]  i_hi,
    output srsm_pkg::t_cmp_res          o_res
);
    import srsm_pkg::*;

    logic [END_W-1:0] w_start;
    logic [END_W-1:0] w_end;
    logic [END_W-1:0] w_span;

    assign w_start = {1'b0, i_start};
    assign w_end   = w_start + {1'b0, i_size};
    assign w_span  = i_hi - i_lo;

    always_comb begin
        o_res.e_end       = w_end;
        o_res.span        = w_span[ADDR_W-1:0];
        o_res.end_lt_lo   = (w_end < i_lo);
        o_res.start_gt_hi = (w_start > i_hi);
        o_res.start_lt_hi = (w_start < i_hi);
        o_res.end_gt_hi   = (w_end > i_hi);
        o_res.start_lt_lo = (w_start < i_lo);
        o_res.lo_lt_end   = (i_lo < w_end);
    end

endmodule

/* hw/rtl/sorted_range_set_merge_top.sv */
// Top level of the sorted range set merge block: sequencer, config and storage.
//
// Keeps up to MAX_RANGES disjoint byte ranges sorted by start in a single
// RAM (one write port, one registered read port). Each transaction on the
// input channel is an insert (op 0) or an overlap query (op 1) and yields
// exactly one result transaction carrying overlap, overflow and the count of
// stored ranges after the item. The input side is not ready while an item is
// in work; a finished result waits in an output register, so the next item
// is accepted while the previous result is still pending. A result that finds
// that register still occupied holds the sequencer in its last state until the
// register frees. Timing is set by the one RAM read port and its registered
// read: each entry visited is read and then evaluated. A query with
// full_extent set reports overlap without reading; otherwise a query stops at
// the first stored entry that overlaps or starts at or after its end, or runs
// past the last one. An insert shifts the entries above its slot up one place
// before it writes the new range, or is dropped with overflow when the set is
// full; a merge absorbs every further entry that starts at or before hi and
// moves the following entries down to close the gap. No clearing pass is
// needed after reset: only entries below the count are ever used. full_extent
// is written through i_cfg_wr_en / i_cfg_wr_data; the user must write it only
// while idle, the block itself does not enforce this.
module sorted_range_set_merge_top #(
    parameter int MAX_RANGES = srsm_pkg::MAX_RANGES_DEF,
    parameter int CNT_W      = $clog2(MAX_RANGES + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_wr_data,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_op,
    input  logic [srsm_pkg::ADDR_W-1:0] i_start_req,
    input  logic [srsm_pkg::ADDR_W-1:0] i_length,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_overlap,
    output logic                        o_overflow,
    output logic [CNT_W-1:0]            o_range_count
);
    import srsm_pkg::*;

    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_MRG_RD,
        S_MRG_EV,
        S_MRG_WR,
        S_CMP_RD,
        S_CMP_WR,
        S_Q_RD,
        S_Q_EV,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic              r_full_extent;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_i, n_i;        // scan / target index
    logic [CNT_W-1:0]  r_j, n_j;        // merge lookahead index
    logic [CNT_W-1:0]  r_k, n_k;        // shift index
    logic [CNT_W-1:0]  r_rm, n_rm;      // entries absorbed by a merge
    logic [ADDR_W-1:0] r_s, n_s;
    logic [ADDR_W-1:0] r_len, n_len;
    logic [END_W-1:0]  r_lo, n_lo;
    logic [END_W-1:0]  r_hi, n_hi;
    logic              r_res_ov, n_res_ov;
    logic              r_res_of, n_res_of;
    logic              r_out_valid, n_out_valid;
    logic              r_overlap, n_overlap;
    logic              r_overflow, n_overflow;
    logic [CNT_W-1:0]  r_out_cnt, n_out_cnt;

    // storage port
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic [IDX_W-1:0]   w_raddr;
    logic [ENTRY_W-1:0] w_rdata;
    t_cmp_res           w_cmp;

    logic               w_accept;
    logic [CNT_W-1:0]   w_k_dec;
    logic [CNT_W:0]     w_src;     // compaction source index, k + removed
    logic               w_full;

    srsm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_RANGES),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    srsm_cmp_unit u_cmp (
        .i_start (w_rdata[ENTRY_W-1:ADDR_W]),
        .i_size  (w_rdata[ADDR_W-1:0]),
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .o_res   (w_cmp)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_k_dec    = r_k - CNT_W'(1);
    assign w_src      = {1'b0, r_k} + {1'b0, r_rm};
    assign w_full     = (r_cnt == CNT_W'(MAX_RANGES));

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_rm        = r_rm;
        n_s         = r_s;
        n_len       = r_len;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_res_ov    = r_res_ov;
        n_res_of    = r_res_of;
        n_out_valid = r_out_valid;
        n_overlap   = r_overlap;
        n_overflow  = r_overflow;
        n_out_cnt   = r_out_cnt;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = w_rdata;
        w_raddr     = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_s      = i_start_req;
                    n_len    = i_length;
                    n_lo     = {1'b0, i_start_req};
                    n_hi     = {1'b0, i_start_req} + {1'b0, i_length};
                    n_i      = '0;
                    n_res_ov = 1'b0;
                    n_res_of = 1'b0;
                    if (i_op == OP_QUERY) begin
                        if (r_full_extent) begin
                            n_res_ov = 1'b1;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_Q_RD;
                        end
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end

            // walk past entries that end before the new range
            S_SCAN_RD: begin
                w_raddr = r_i[IDX_W-1:0];
                if (r_i >= r_cnt) begin
                    if (w_full) begin
                        n_res_of = 1'b1;
                        n_state  = S_DONE;
                    end else begin
                        n_k     = r_cnt;
                        n_state = (r_cnt == r_i) ? S_INS_PUT : S_INS_RD;
                    end
                end else begin
                    n_state = S_SCAN_EV;
                end
            end

            S_SCAN_EV: begin
                if (w_cmp.end_lt_lo) begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = S_SCAN_RD;
                end else if (w_cmp.start_gt_hi) begin
                    if (w_full) begin
                        n_res_of = 1'b1;
                        n_state  = S_DONE;
                    end else begin
                        n_k     = r_cnt;
                        n_state = S_INS_RD;
                    end
                end else begin
                    if (w_cmp.start_lt_lo) begin
                        n_lo = {1'b0, w_rdata[ENTRY_W-1:ADDR_W]};
                    end
                    if (w_cmp.end_gt_hi) begin
                        n_hi = w_cmp.e_end;
                    end
                    n_j     = r_i + CNT_W'(1);
                    n_state = S_MRG_RD;
                end
            end

            // open a slot at r_i by moving entries up one place
            S_INS_RD: begin
                w_raddr = w_k_dec[IDX_W-1:0];
                n_state = S_INS_WR;
            end

            S_INS_WR: begin
                w_we    = 1'b1;
                w_waddr = r_k[IDX_W-1:0];
                w_wdata = w_rdata;
                n_k     = w_k_dec;
                n_state = (w_k_dec == r_i) ? S_INS_PUT : S_INS_RD;
            end

            S_INS_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_i[IDX_W-1:0];
                w_wdata = {r_s, r_len};
                n_cnt   = r_cnt + CNT_W'(1);
                n_state = S_DONE;
            end

            // absorb following entries that start at or before hi
            S_MRG_RD: begin
                w_raddr = r_j[IDX_W-1:0];
                n_state = (r_j >= r_cnt) ? S_MRG_WR : S_MRG_EV;
            end

            S_MRG_EV: begin
                if (!w_cmp.start_gt_hi) begin
                    if (w_cmp.end_gt_hi) begin
                        n_hi = w_cmp.e_end;
                    end
                    n_j     = r_j + CNT_W'(1);
                    n_state = S_MRG_RD;
                end else begin
                    n_state = S_MRG_WR;
                end
            end

            S_MRG_WR: begin
                w_we    = 1'b1;
                w_waddr = r_i[IDX_W-1:0];
                w_wdata = {r_lo[ADDR_W-1:0], w_cmp.span};
                n_k     = r_i + CNT_W'(1);
                n_rm    = r_j - r_i - CNT_W'(1);
                n_state = S_CMP_RD;
            end

            // close the gap left by absorbed entries
            S_CMP_RD: begin
                w_raddr = w_src[IDX_W-1:0];
                if (w_src < {1'b0, r_cnt}) begin
                    n_state = S_CMP_WR;
                end else begin
                    n_cnt   = r_cnt - r_rm;
                    n_state = S_DONE;
                end
            end

            S_CMP_WR: begin
                w_we    = 1'b1;
                w_waddr = r_k[IDX_W-1:0];
                w_wdata = w_rdata;
                n_k     = r_k + CNT_W'(1);
                n_state = S_CMP_RD;
            end

            // query: lo = start, hi = start + length
            S_Q_RD: begin
                w_raddr = r_i[IDX_W-1:0];
                n_state = (r_i >= r_cnt) ? S_DONE : S_Q_EV;
            end

            S_Q_EV: begin
                if (w_cmp.start_lt_hi && w_cmp.lo_lt_end) begin
                    n_res_ov = 1'b1;
                    n_state  = S_DONE;
                end else if (!w_cmp.start_lt_hi) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = S_Q_RD;
                end
            end

            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_overlap   = r_res_ov;
                    n_overflow  = r_res_of;
                    n_out_cnt   = r_cnt;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
            r_full_extent <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_full_extent <= i_cfg_wr_data;
            end
        end
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_rm       <= n_rm;
        r_s        <= n_s;
        r_len      <= n_len;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_res_ov   <= n_res_ov;
        r_res_of   <= n_res_of;
        r_overlap  <= n_overlap;
        r_overflow <= n_overflow;
        r_out_cnt  <= n_out_cnt;
    end

    assign o_out_valid   = r_out_valid;
    assign o_overlap     = r_overlap;
    assign o_overflow    = r_overflow;
    assign o_range_count = r_out_cnt;

endmodule
